### hw/rtl/gauge_needle_smoother_assert.svh
// Assertion macros for the gauge needle smoother.
// No dependencies; taken in by files that carry concurrent assertions.
`ifndef GAUGE_NEEDLE_SMOOTHER_ASSERT_SVH
`define GAUGE_NEEDLE_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset
`define GNS_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gauge needle smoother: assertion failed");
// Assertion on the house clock and reset names
`define GNS_ASSERT(lbl, prop) `GNS_ASSERT_AT(lbl, clk_i, rst_ni, prop)
`else
`define GNS_ASSERT_AT(lbl, clk, rst_n, prop)
`define GNS_ASSERT(lbl, prop)
`endif
`endif

### hw/rtl/gns_pkg.sv
// Shared constants and types of the gauge needle smoother.
// No dependencies; used by the interfaces, the datapath and the top level.
package gns_pkg;

  // Field widths
  localparam int NumChannels = 4;
  localparam int ChanW       = 2;
  localparam int TargetW     = 15;
  localparam int PosW        = 16;
  localparam int VelW        = 17;
  localparam int AccW        = 32;
  localparam int FracBits    = 16;
  localparam int ShiftW      = 4;
  localparam int LimitW      = 8;
  localparam int DShiftW     = $clog2(FracBits + 1);
  // step arithmetic: position differences plus velocity plus limit, with headroom
  localparam int StepW       = 20;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgShiftBase = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitBase = 3'd4;

  localparam logic [ShiftW-1:0] ShiftReset [4] = '{4'd8, 4'd8, 4'd8, 4'd7};
  localparam logic [LimitW-1:0] LimitReset [4] = '{8'd2, 8'd6, 8'd7, 8'd1};

  localparam logic [AccW-1:0] FracMask = (AccW'(1) << FracBits) - AccW'(1);

  // Per-channel filter and needle state
  typedef struct packed {
    logic [AccW-1:0] acc1;
    logic [AccW-1:0] acc2;
    logic [PosW-1:0] pos;
    logic [VelW-1:0] vel;
  } chan_state_t;

  // What the datapath reports for one word
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            updated;
  } calc_res_t;

endpackage

### hw/rtl/gns_if.sv
// Valid/ready channel interfaces of the gauge needle smoother.
// Depends on gns_pkg for field widths.
interface gns_tick_if;
  logic                         valid;
  logic                         ready;
  logic [gns_pkg::ChanW-1:0]    channel;
  logic [gns_pkg::TargetW-1:0]  target;

  modport source (output valid, output channel, output target, input ready);
  modport sink   (input valid, input channel, input target, output ready);
endinterface

interface gns_pos_if;
  logic                              valid;
  logic                              ready;
  logic [gns_pkg::ChanW-1:0]         out_channel;
  logic signed [gns_pkg::PosW-1:0]   position;
  logic                              updated;

  modport source (output valid, output out_channel, output position, output updated,
                  input ready);
  modport sink   (input valid, input out_channel, input position, input updated,
                  output ready);
endinterface

### hw/rtl/gns_calc.sv
// Combinational datapath: two cascaded shift filters, step and step-change clip.
// Depends on gns_pkg.
module gns_calc (
  input  gns_pkg::chan_state_t         st_i,
  input  logic [gns_pkg::ShiftW-1:0]   shift_i,
  input  logic [gns_pkg::LimitW-1:0]   limit_i,
  input  logic [gns_pkg::TargetW-1:0]  target_i,
  output gns_pkg::chan_state_t         st_o,
  output gns_pkg::calc_res_t           res_o
);
  import gns_pkg::*;

  logic                      hit;
  logic [DShiftW-1:0]        d;
  logic signed [AccW-1:0]    f, f_sh, s, s_sh, a1, a1_sh, a2, a2_wb;
  logic [AccW-1:0]           tgt_sh;
  logic signed [PosW-1:0]    newp, old_p, newp_c;
  logic signed [VelW-1:0]    vel_in;
  logic signed [StepW-1:0]   lim_s, step0, step1, vel_s, acc, step2;
  logic                      c1, c2, clipped;

  // target already reached: nothing moves
  assign hit = (st_i.pos == PosW'(target_i));

  // shift saturates at the fraction width
  assign d = (DShiftW'(shift_i) > DShiftW'(FracBits)) ? DShiftW'(FracBits)
                                                      : DShiftW'(shift_i);

  // first filter
  assign f      = st_i.acc1;
  assign f_sh   = f >>> d;
  assign tgt_sh = AccW'(target_i) << (DShiftW'(FracBits) - d);
  assign a1     = f - f_sh + tgt_sh;

  // second filter fed by the first
  assign s     = st_i.acc2;
  assign s_sh  = s >>> d;
  assign a1_sh = a1 >>> d;
  assign a2    = s - s_sh + a1_sh;
  assign newp  = a2[FracBits +: PosW];

  // step clip against the old position
  assign old_p = st_i.pos;
  assign lim_s = {{(StepW-LimitW){1'b0}}, limit_i};
  assign step0 = StepW'(newp) - StepW'(old_p);

  always_comb begin
    c1    = 1'b0;
    step1 = step0;
    if (step0 < -lim_s) begin
      step1 = -lim_s;
      c1    = 1'b1;
    end else if (step0 > lim_s) begin
      step1 = lim_s;
      c1    = 1'b1;
    end
  end

  // step-change clip against the previous velocity
  assign vel_in = st_i.vel;
  assign vel_s  = StepW'(vel_in);
  assign acc    = step1 - vel_s;

  always_comb begin
    c2    = 1'b0;
    step2 = step1;
    if (acc < -lim_s) begin
      step2 = vel_s - lim_s;
      c2    = 1'b1;
    end else if (acc > lim_s) begin
      step2 = vel_s + lim_s;
      c2    = 1'b1;
    end
  end

  assign clipped = c1 | c2;

  // on a clip the position goes back into the integer half, fraction kept
  assign newp_c = clipped ? (old_p + step2[PosW-1:0]) : newp;
  assign a2_wb  = clipped ? ((AccW'(newp_c) << FracBits) | (a2 & FracMask)) : a2;

  always_comb begin
    if (hit) begin
      st_o         = st_i;
      res_o.position = st_i.pos;
      res_o.updated  = 1'b0;
    end else begin
      st_o.acc1      = a1;
      st_o.acc2      = a2_wb;
      st_o.pos       = newp_c;
      st_o.vel       = step2[VelW-1:0];
      res_o.position = newp_c;
      res_o.updated  = 1'b1;
    end
  end

endmodule

### hw/rtl/gauge_needle_smoother.sv
// Top level of the gauge needle smoother: input register, per-channel state,
// configuration registers, result register. Depends on gns_pkg, gns_if, gns_calc.
//
// Use:
//   tick_i carries words of (channel, target); pos_o returns exactly one word
//   per tick of (out_channel, position, updated). Both are valid/ready.
//   A tick is caught in an input register; as it leaves that register the
//   datapath runs the two cascaded filters and the clips for that channel,
//   writes the channel state and loads the result register. One tick is
//   taken every cycle while pos_o does not stall.
//   A tick whose target equals the stored position returns that position
//   with updated low and leaves the state alone.
//   When pos_o stalls, the result register holds its word and the input
//   register still takes one more tick; tick_i.ready drops only when both
//   are full.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0..3 filter shift per channel, 4..7 limit per channel). Write only while
//   idle.
//   Reset clears all filter state, velocities and positions to zero and puts
//   the shifts and limits at their defaults; no words are held.
`include "gauge_needle_smoother_assert.svh"
module gauge_needle_smoother (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gns_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gns_pkg::CfgDataW-1:0]  cfg_data_i,
  gns_tick_if.sink                      tick_i,
  gns_pos_if.source                     pos_o
);
  import gns_pkg::*;

  logic [ShiftW-1:0]   shift_q [NumChannels];
  logic [LimitW-1:0]   limit_q [NumChannels];
  chan_state_t         st_q    [NumChannels];

  logic                in_vld_q;
  logic [ChanW-1:0]    in_ch_q;
  logic [TargetW-1:0]  in_tgt_q;

  logic                out_vld_q;
  logic [ChanW-1:0]    out_ch_q;
  logic [PosW-1:0]     out_pos_q;
  logic                out_upd_q;

  logic                present;
  logic                adv;
  chan_state_t         st_sel, st_d;
  logic [ShiftW-1:0]   shift_sel;
  logic [LimitW-1:0]   limit_sel;
  calc_res_t           res;

  // handshake: a word moves on when the result register is free or draining
  assign adv          = in_vld_q && (!out_vld_q || pos_o.ready);
  assign tick_i.ready = !in_vld_q || adv;

  assign present   = ({1'b0, in_ch_q} < (ChanW + 1)'(NumChannels));
  assign st_sel    = present ? st_q[in_ch_q]    : '0;
  assign shift_sel = present ? shift_q[in_ch_q] : '0;
  assign limit_sel = present ? limit_q[in_ch_q] : '0;

  gns_calc u_calc (
    .st_i     (st_sel),
    .shift_i  (shift_sel),
    .limit_i  (limit_sel),
    .target_i (in_tgt_q),
    .st_o     (st_d),
    .res_o    (res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        shift_q[c] <= ShiftReset[c];
        limit_q[c] <= LimitReset[c];
      end
    end else if (cfg_we_i) begin
      for (int c = 0; c < NumChannels; c++) begin
        if (cfg_idx_i == CfgShiftBase + CfgIdxW'(c)) begin
          shift_q[c] <= cfg_data_i[ShiftW-1:0];
        end
        if (cfg_idx_i == CfgLimitBase + CfgIdxW'(c)) begin
          limit_q[c] <= cfg_data_i[LimitW-1:0];
        end
      end
    end
  end

  // channel state, written as the word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        st_q[c] <= '0;
      end
    end else if (adv && present) begin
      st_q[in_ch_q] <= st_d;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.valid && tick_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_ch_q  <= tick_i.channel;
      in_tgt_q <= tick_i.target;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (pos_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload; an absent channel reports zero, not updated
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch_q  <= in_ch_q;
      out_pos_q <= present ? res.position : '0;
      out_upd_q <= present && res.updated;
    end
  end

  assign pos_o.valid       = out_vld_q;
  assign pos_o.out_channel = out_ch_q;
  assign pos_o.position    = out_pos_q;
  assign pos_o.updated     = out_upd_q;

  // a full input register behind a stalled result blocks new ticks
  `GNS_ASSERT(a_stall_blocks_ready, in_vld_q && out_vld_q && !pos_o.ready |-> !tick_i.ready)
  // every word that leaves the input register shows up as a result
  `GNS_ASSERT(a_adv_gives_result, adv |=> pos_o.valid)
  // a tick that changes nothing leaves its channel state untouched
  `GNS_ASSERT(a_no_update_keeps_state,
    adv && !res.updated |=> st_q[$past(in_ch_q)] == $past(st_sel))

endmodule

### tb/tb_gauge_needle_smoother.sv
// Self-checking testbench of the gauge needle smoother: directed ticks from a table,
// then random phases under several shift/limit settings and idling patterns.
// Depends on gns_pkg, gns_if and the gauge_needle_smoother top level.
module tb_gauge_needle_smoother;
  import gns_pkg::*;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // One result word as the block should report it
  typedef struct packed {
    logic [ChanW-1:0] ch;
    logic [PosW-1:0]  pos;
    logic             upd;
  } needle_word_t;

  // One directed tick; at_pos aims at the current position, typed carries a fixed result
  typedef struct packed {
    logic [ChanW-1:0]   ch;
    logic [TargetW-1:0] tgt;
    logic               at_pos;
    logic               typed;
    logic [PosW-1:0]    exp_pos;
    logic               exp_upd;
  } tick_row_t;

  localparam int CycleLimit    = 400000;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 250;
  localparam int SqueezeCycles = 300;
  localparam int NumDirected   = 22;

  localparam tick_row_t DirectedTicks [NumDirected] = '{
    // target already reached straight after reset
    '{2'd0, 15'd0,     1'b0, 1'b1, 16'd0, 1'b0},
    '{2'd1, 15'd0,     1'b0, 1'b1, 16'd0, 1'b0},
    '{2'd2, 15'd0,     1'b0, 1'b1, 16'd0, 1'b0},
    '{2'd3, 15'd0,     1'b0, 1'b1, 16'd0, 1'b0},
    // full-scale targets, velocity ramps against the limit
    '{2'd0, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd0, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd0, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd1, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd2, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'h7fff,  1'b0, 1'b0, 16'd0, 1'b0},
    // reversal: step change clipped the other way
    '{2'd0, 15'd0,     1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd1, 15'h5555,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd2, 15'h2aaa,  1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd1, 15'h4000,  1'b0, 1'b0, 16'd0, 1'b0},
    // target equal to the position reached so far, then two ticks to targets near zero
    '{2'd0, 15'd0,     1'b1, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'd0,     1'b1, 1'b0, 16'd0, 1'b0},
    '{2'd2, 15'd0,     1'b1, 1'b0, 16'd0, 1'b0},
    '{2'd3, 15'd1,     1'b0, 1'b0, 16'd0, 1'b0},
    '{2'd2, 15'd0,     1'b0, 1'b0, 16'd0, 1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  gns_tick_if tick_bus ();
  gns_pos_if  pos_bus ();

  gauge_needle_smoother u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_bus),
    .pos_o      (pos_bus)
  );

  // Predicted per-channel state and settings
  logic [AccW-1:0]   acc1_st   [NumChannels];
  logic [AccW-1:0]   acc2_st   [NumChannels];
  logic [PosW-1:0]   pos_st    [NumChannels];
  logic [VelW-1:0]   vel_st    [NumChannels];
  logic [ShiftW-1:0] shift_cfg [NumChannels];
  logic [LimitW-1:0] limit_cfg [NumChannels];

  needle_word_t expected_words [$];
  int           mismatches;
  int           cycle_count;
  int           squeeze_len;
  int           hold_left;
  idle_mode_e   idle_mode;

  // Clock, period 2
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("gauge_needle_smoother verification failed");
      $finish;
    end
  end

  // Cascaded filters, then step and step-change clip with write-back on a clip
  function automatic needle_word_t smooth_tick(input logic [ChanW-1:0] ch,
                                               input logic [TargetW-1:0] tgt);
    needle_word_t       w;
    int                 d;
    logic [AccW-1:0]    boost, dec1, dec2, dec3, a1, a2;
    logic signed [AccW-1:0] s_acc1, s_acc2, s_a1;
    logic [PosW-1:0]    newp;
    logic signed [PosW-1:0] s_old, s_new;
    logic signed [VelW-1:0] s_vel;
    int                 old_p, lim, stp, vel_i, dv;
    logic               clipped;
    w.ch  = ch;
    w.pos = pos_st[ch];
    w.upd = 1'b0;
    if (pos_st[ch] == {1'b0, tgt}) return w;
    d = int'(shift_cfg[ch]);
    if (d > FracBits) d = FracBits;
    // arithmetic shifts kept in their own assignments so they stay signed
    s_acc1 = acc1_st[ch];
    s_acc2 = acc2_st[ch];
    dec1   = s_acc1 >>> d;
    dec2   = s_acc2 >>> d;
    boost  = AccW'(tgt) << (FracBits - d);
    a1     = acc1_st[ch] - dec1 + boost;
    s_a1   = a1;
    dec3   = s_a1 >>> d;
    a2     = acc2_st[ch] - dec2 + dec3;
    newp   = a2[FracBits +: PosW];
    s_old  = pos_st[ch];
    s_new  = newp;
    old_p  = s_old;
    lim    = int'(limit_cfg[ch]);
    stp    = s_new - old_p;
    clipped = 1'b0;
    if (stp < -lim) begin
      stp = -lim;
      clipped = 1'b1;
    end else if (stp > lim) begin
      stp = lim;
      clipped = 1'b1;
    end
    s_vel = vel_st[ch];
    vel_i = s_vel;
    dv    = stp - vel_i;
    if (dv < -lim) begin
      stp = vel_i - lim;
      clipped = 1'b1;
    end else if (dv > lim) begin
      stp = vel_i + lim;
      clipped = 1'b1;
    end
    if (clipped) begin
      newp = PosW'(old_p + stp);
      a2   = {newp, a2[FracBits-1:0]};
    end
    acc1_st[ch] = a1;
    acc2_st[ch] = a2;
    pos_st[ch]  = newp;
    vel_st[ch]  = VelW'(stp);
    w.pos = newp;
    w.upd = 1'b1;
    return w;
  endfunction

  function automatic logic sender_rests();
    case (idle_mode)
      IdleSender: return $urandom_range(0, 99) < 49;
      IdleBoth:   return $urandom_range(0, 99) < 8;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_rests();
    case (idle_mode)
      IdleReceiver: return $urandom_range(0, 99) < 49;
      IdleBoth:     return $urandom_range(0, 99) < 8;
      default:      return 1'b0;
    endcase
  endfunction

  // Random target: often the current position or close to it, sometimes full scale
  function automatic logic [TargetW-1:0] pick_target(input logic [ChanW-1:0] ch);
    int roll;
    int near_p;
    roll = $urandom_range(0, 99);
    if (roll < 15) return pos_st[ch][TargetW-1:0];
    if (roll < 25) return '0;
    if (roll < 35) return '1;
    if (roll < 60) begin
      near_p = int'(pos_st[ch][TargetW-1:0]) + int'($urandom_range(0, 64)) - 32;
      return TargetW'(near_p);
    end
    return TargetW'($urandom_range(0, 32767));
  endfunction

  // Offer one tick, wait for its acceptance, then record what should come back
  task automatic push_tick(input logic [ChanW-1:0] ch, input logic [TargetW-1:0] tgt,
                           input logic typed, input logic [PosW-1:0] t_pos,
                           input logic t_upd);
    needle_word_t w;
    while (sender_rests()) begin
      @(negedge clk_i);
      tick_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    tick_bus.valid   <= 1'b1;
    tick_bus.channel <= ch;
    tick_bus.target  <= tgt;
    do @(posedge clk_i); while (!tick_bus.ready);
    w = smooth_tick(ch, tgt);
    if (typed) begin
      w.pos = t_pos;
      w.upd = t_upd;
    end
    expected_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx < CfgLimitBase) shift_cfg[idx - CfgShiftBase] = data[ShiftW-1:0];
    else                    limit_cfg[idx - CfgLimitBase] = data[LimitW-1:0];
  endtask

  // Shifts and limits for each phase: extremes first, then random mixes
  task automatic load_phase_config(input int p);
    logic [CfgDataW-1:0] sv, lv;
    for (int c = 0; c < NumChannels; c++) begin
      case (p)
        0: begin sv = 8'd1;  lv = 8'd255; end
        1: begin sv = 8'd15; lv = 8'd0;   end
        2: begin sv = 8'd0;  lv = 8'd255; end
        5: begin sv = CfgDataW'($urandom_range(0, 255)); lv = 8'd0; end
        default: begin
          sv = CfgDataW'($urandom_range(0, 255));
          lv = CfgDataW'($urandom_range(0, 255));
        end
      endcase
      write_reg(CfgShiftBase + CfgIdxW'(c), sv);
      write_reg(CfgLimitBase + CfgIdxW'(c), lv);
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Let every outstanding word drain, then let the clock run on before returning
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (squeeze_len != 0) begin
      hold_left   = squeeze_len;
      squeeze_len = 0;
    end
    if (hold_left > 0) begin
      pos_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      pos_bus.ready <= !receiver_rests();
    end
  end

  // Output checker
  always @(posedge clk_i) begin : check_words
    needle_word_t want;
    if (rst_ni && pos_bus.valid && pos_bus.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_channel %0d position %0d updated %0b",
               pos_bus.out_channel, pos_bus.position, pos_bus.updated);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (pos_bus.out_channel !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, pos_bus.out_channel);
          mismatches++;
        end
        if (pos_bus.position !== want.pos) begin
          $error("position: expected %0d, got %0d", $signed(want.pos), pos_bus.position);
          mismatches++;
        end
        if (pos_bus.updated !== want.upd) begin
          $error("updated: expected %0b, got %0b", want.upd, pos_bus.updated);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin : run
    logic [ChanW-1:0]   ch;
    logic [TargetW-1:0] tgt;
    mismatches       = 0;
    cycle_count      = 0;
    squeeze_len      = 0;
    hold_left        = 0;
    idle_mode        = IdleNone;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    tick_bus.valid   = 1'b0;
    tick_bus.channel = '0;
    tick_bus.target  = '0;
    pos_bus.ready    = 1'b0;
    shift_cfg = '{4'd8, 4'd8, 4'd8, 4'd7};
    limit_cfg = '{8'd2, 8'd6, 8'd7, 8'd1};
    for (int c = 0; c < NumChannels; c++) begin
      acc1_st[c] = '0;
      acc2_st[c] = '0;
      pos_st[c]  = '0;
      vel_st[c]  = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under the reset settings
    for (int i = 0; i < NumDirected; i++) begin
      tgt = DirectedTicks[i].at_pos ? pos_st[DirectedTicks[i].ch][TargetW-1:0]
                                    : DirectedTicks[i].tgt;
      push_tick(DirectedTicks[i].ch, tgt, DirectedTicks[i].typed,
                DirectedTicks[i].exp_pos, DirectedTicks[i].exp_upd);
    end
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
    drain();

    // random phases, each under its own settings and idling pattern
    for (int p = 0; p < NumPhases; p++) begin
      load_phase_config(p);
      idle_mode = idle_mode_e'(p % 4);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 4 && n == 40) squeeze_len = SqueezeCycles;
        ch  = ChanW'($urandom_range(0, NumChannels - 1));
        tgt = pick_target(ch);
        push_tick(ch, tgt, 1'b0, '0, 1'b0);
      end
      @(negedge clk_i);
      tick_bus.valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gauge_needle_smoother verification clean");
    end else begin
      $display("gauge_needle_smoother verification failed");
    end
    $finish;
  end

endmodule
